// File: hdl/esa_pkg.sv
// ----------------------------------------------------------------------------
// esa_pkg - shared codes for the entity slot allocator
// Function codes, status codes and controller state encoding.
// ----------------------------------------------------------------------------
package esa_pkg;

  // Function codes carried by the func field
  localparam logic [2:0] FUNC_ALLOC  = 3'd0;
  localparam logic [2:0] FUNC_REMOVE = 3'd1;
  localparam logic [2:0] FUNC_FLUSH  = 3'd2;
  localparam logic [2:0] FUNC_ATTACH = 3'd3;
  localparam logic [2:0] FUNC_DETACH = 3'd4;
  localparam logic [2:0] FUNC_QUERY  = 3'd5;

  // Status codes carried by the status field
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
  localparam logic [1:0] STATUS_Q_FULL   = 2'd2;
  localparam logic [1:0] STATUS_NOT_LIVE = 2'd3;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    S_CLEAR    = 5'b00001,
    S_IDLE     = 5'b00010,
    S_EXEC     = 5'b00100,
    S_FLUSH    = 5'b01000,
    S_FLUSH_RD = 5'b10000
  } state_t;

endpackage

// File: hdl/esa_ram.sv
// ----------------------------------------------------------------------------
// esa_ram - generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module esa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/entity_slot_allocator.sv
// ----------------------------------------------------------------------------
// entity_slot_allocator - bitmap slot allocator with deferred removal
// Allocates entity slots, tracks per-slot component masks, a high-water
// mark and a queue of pending removals that a flush command retires.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command word: func,
//   slot_index, comp_kind. Output channel (out_valid / out_stall) returns
//   one result word per command: status, granted_slot, slot_live,
//   comp_present, high_water, pending_removals.
//   Single-slot commands issue the component-mask RAM read in the accepting
//   cycle; the S_EXEC state that follows does the read-modify-write and
//   loads the result register once the output register is free. A new
//   command is accepted once the previous one has loaded its result, so
//   commands do not overlap. A flush walks the removal-queue RAM one entry
//   per cycle, rereads the addressed slot's mask in S_FLUSH_RD, then loads
//   its result in S_EXEC.
//   After reset the block runs a clearing pass over the component-mask RAM
//   with in_stall high; then it takes commands.
//   The result sits in an output register; while out_stall is high it
//   holds, and a finished command waits for that register to free up
//   before it writes back any state.
// ----------------------------------------------------------------------------
module entity_slot_allocator
  import esa_pkg::*;
#(
  parameter int SLOT_COUNT = 64,
  parameter int COMP_KINDS = 8
) (
  input  logic       clk,
  input  logic       rst,
  // command channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] func,
  input  logic [6:0] slot_index,
  input  logic [2:0] comp_kind,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [5:0] granted_slot,
  output logic       slot_live,
  output logic       comp_present,
  output logic [6:0] high_water,
  output logic [6:0] pending_removals
);

  localparam int SW = $clog2(SLOT_COUNT);        // slot address width
  localparam int TW = $clog2(SLOT_COUNT + 1);    // mark and fill width
  localparam int KW = (COMP_KINDS > 1) ? $clog2(COMP_KINDS) : 1;

  // --------------------------------------------------------------------------
  // Search helpers over the live bitmap
  // --------------------------------------------------------------------------
  function automatic logic [SW-1:0] lowest_free(input logic [SLOT_COUNT-1:0] map);
    logic [SW-1:0] idx;
    idx = '0;
    for (int e = SLOT_COUNT - 1; e >= 0; e--) begin
      if (!map[e]) begin
        idx = SW'(e);
      end
    end
    return idx;
  endfunction

  function automatic logic [TW-1:0] top_of(input logic [SLOT_COUNT-1:0] map);
    logic [TW-1:0] m;
    m = '0;
    for (int e = 0; e < SLOT_COUNT; e++) begin
      if (map[e]) begin
        m = TW'(e + 1);
      end
    end
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t                state;
  logic [SLOT_COUNT-1:0] live_map;
  logic [TW-1:0]         top_mark;
  logic [TW-1:0]         queue_fill;
  logic [SW-1:0]         clr_ptr;
  logic [TW-1:0]         rd_ptr;
  logic                  proc_valid;

  // captured command
  logic [2:0]            op_func;
  logic [SW-1:0]         op_slot;
  logic                  op_in_range;
  logic [KW-1:0]         op_kind;
  logic                  op_kind_ok;
  logic                  op_found;
  logic [SW-1:0]         op_free;

  // memory ports
  logic                  comp_we, comp_re;
  logic [SW-1:0]         comp_waddr, comp_raddr;
  logic [COMP_KINDS-1:0] comp_wdata, comp_rdata;
  logic                  q_we, q_re;
  logic [SW-1:0]         q_waddr, q_raddr;
  logic [SW-1:0]         q_wdata, q_rdata;

  // component masks, cleared by a sweep after reset
  esa_ram #(.WIDTH(COMP_KINDS), .DEPTH(SLOT_COUNT)) u_comp_ram (
    .clk   (clk),
    .we    (comp_we),
    .waddr (comp_waddr),
    .wdata (comp_wdata),
    .re    (comp_re),
    .raddr (comp_raddr),
    .rdata (comp_rdata)
  );

  // removal queue, only entries below queue_fill are read
  esa_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // --------------------------------------------------------------------------
  // Decode of the incoming word
  // --------------------------------------------------------------------------
  logic          accept;
  logic [SW-1:0] slot_addr;
  logic          slot_in_range;
  logic          kind_ok;
  logic [SW-1:0] free_idx;

  assign in_stall      = (state != S_IDLE);
  assign accept        = in_valid && !in_stall;
  assign slot_addr     = SW'(slot_index);
  assign slot_in_range = (32'(slot_index) < 32'(SLOT_COUNT));
  assign kind_ok       = (32'(comp_kind) < 32'(COMP_KINDS));
  assign free_idx      = lowest_free(live_map);

  // --------------------------------------------------------------------------
  // Execute stage: mask RAM data is valid here
  // --------------------------------------------------------------------------
  logic                  out_free;
  logic                  load_res;
  logic [COMP_KINDS-1:0] kind_bit;
  logic [COMP_KINDS-1:0] mask_mod;
  logic                  addr_live;
  logic                  q_full;
  logic                  remove_ok;
  logic                  mask_write;
  logic [TW-1:0]         res_top;
  logic [1:0]            res_status;
  logic [5:0]            res_granted;
  logic                  res_live;
  logic                  res_comp;

  assign out_free  = !out_valid || !out_stall;
  assign load_res  = (state == S_EXEC) && out_free;
  assign kind_bit  = COMP_KINDS'(1) << op_kind;
  assign mask_mod  = (op_func == FUNC_ATTACH) ? (comp_rdata | kind_bit)
                                              : (comp_rdata & ~kind_bit);
  assign addr_live = op_in_range && live_map[op_slot];
  assign q_full    = (queue_fill == TW'(SLOT_COUNT));
  assign remove_ok = (op_func == FUNC_REMOVE) && addr_live && !q_full;
  assign mask_write = ((op_func == FUNC_ATTACH) || (op_func == FUNC_DETACH))
                      && op_in_range && op_kind_ok;

  always_comb begin
    res_status  = STATUS_OK;
    res_granted = '0;
    res_live    = addr_live;
    res_comp    = op_in_range && op_kind_ok && comp_rdata[op_kind];
    res_top     = top_mark;
    case (op_func)
      FUNC_ALLOC: begin
        if (op_found) begin
          res_granted = 6'(op_free);
          res_live    = 1'b1;
          res_comp    = op_kind_ok && comp_rdata[op_kind];
          if (top_mark <= TW'(op_free)) begin
            res_top = TW'(op_free) + TW'(1);
          end
        end else begin
          res_status = STATUS_NO_FREE;
          res_live   = 1'b0;
          res_comp   = 1'b0;
        end
      end
      FUNC_REMOVE: begin
        if (!addr_live) begin
          res_status = STATUS_NOT_LIVE;
        end else if (q_full) begin
          res_status = STATUS_Q_FULL;
        end
      end
      FUNC_ATTACH, FUNC_DETACH: begin
        if (!op_in_range) begin
          res_status = STATUS_NOT_LIVE;
        end else begin
          res_comp = op_kind_ok && mask_mod[op_kind];
        end
      end
      default: begin
        // flush, query and unused codes report the addressed slot as is
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Flush walk: one queue entry read per cycle, processed the next cycle
  // --------------------------------------------------------------------------
  logic                  issue;
  logic                  proc_live;
  logic [SLOT_COUNT-1:0] map_cleared;

  assign issue       = (rd_ptr < queue_fill);
  assign proc_live   = proc_valid && live_map[q_rdata];
  assign map_cleared = live_map & ~(SLOT_COUNT'(1) << q_rdata);

  // --------------------------------------------------------------------------
  // Memory port control
  // --------------------------------------------------------------------------
  always_comb begin
    comp_we    = 1'b0;
    comp_waddr = op_slot;
    comp_wdata = mask_mod;
    comp_re    = 1'b0;
    comp_raddr = slot_addr;
    q_we       = 1'b0;
    q_waddr    = queue_fill[SW-1:0];
    q_wdata    = op_slot;
    q_re       = 1'b0;
    q_raddr    = rd_ptr[SW-1:0];
    case (state)
      S_CLEAR: begin
        comp_we    = 1'b1;
        comp_waddr = clr_ptr;
        comp_wdata = '0;
      end
      S_IDLE: begin
        comp_re = in_valid;
        if (func == FUNC_ALLOC) begin
          comp_raddr = free_idx;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          comp_we = mask_write;
          q_we    = remove_ok;
        end
      end
      S_FLUSH: begin
        q_re = issue;
        if (proc_live) begin
          // drop every component of a retired slot
          comp_we    = 1'b1;
          comp_waddr = q_rdata;
          comp_wdata = '0;
        end
      end
      S_FLUSH_RD: begin
        comp_re    = 1'b1;
        comp_raddr = op_slot;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      live_map   <= '0;
      top_mark   <= '0;
      queue_fill <= '0;
      clr_ptr    <= '0;
      rd_ptr     <= '0;
      proc_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // load a new word, hold a stalled one, drop a taken one
      out_valid <= load_res || (out_valid && out_stall);
      case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + SW'(1);
          if (clr_ptr == SW'(SLOT_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            rd_ptr     <= '0;
            proc_valid <= 1'b0;
            state      <= (func == FUNC_FLUSH) ? S_FLUSH : S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state     <= S_IDLE;
            top_mark  <= res_top;
            if ((op_func == FUNC_ALLOC) && op_found) begin
              live_map[op_free] <= 1'b1;
            end
            if (remove_ok) begin
              queue_fill <= queue_fill + TW'(1);
            end
          end
        end
        S_FLUSH: begin
          proc_valid <= issue;
          if (issue) begin
            rd_ptr <= rd_ptr + TW'(1);
          end else begin
            queue_fill <= '0;
            state      <= S_FLUSH_RD;
          end
          if (proc_live) begin
            live_map[q_rdata] <= 1'b0;
            if (top_mark == TW'(q_rdata) + TW'(1)) begin
              top_mark <= top_of(map_cleared);
            end
          end
        end
        S_FLUSH_RD: begin
          state <= S_EXEC;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Command capture and result register (payload, no reset)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func     <= func;
      op_slot     <= slot_addr;
      op_in_range <= slot_in_range;
      op_kind     <= KW'(comp_kind);
      op_kind_ok  <= kind_ok;
      op_found    <= ~&live_map;
      op_free     <= free_idx;
    end
    if ((state == S_EXEC) && out_free) begin
      status           <= res_status;
      granted_slot     <= res_granted;
      slot_live        <= res_live;
      comp_present     <= res_comp;
      high_water       <= 7'(res_top);
      pending_removals <= 7'(queue_fill + TW'(remove_ok));
    end
  end

endmodule

// File: hdl/esa_checker.sv
// ----------------------------------------------------------------------------
// esa_checker - port-level checks for the entity slot allocator
// Watches the result channel for consistency of the reported fields.
// ----------------------------------------------------------------------------
module esa_checker
  import esa_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic [5:0] granted_slot,
  input logic       slot_live,
  input logic       comp_present,
  input logic [6:0] high_water
);

  // a stalled result word holds its status and high-water mark
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(high_water))
    else $error("result word changed while stalled");

  // a failed allocation grants nothing
  a_no_free: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_NO_FREE) |->
      (granted_slot == 6'd0) && !slot_live && !comp_present)
    else $error("failed allocation reports a slot");

  // a not-live status never reports a live slot
  a_not_live: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_NOT_LIVE) |-> !slot_live)
    else $error("not-live status with live slot");

  // a nonzero granted slot is live and reports OK status
  a_grant_live: assert property (@(posedge clk) disable iff (rst)
    out_valid && (granted_slot != 6'd0) |-> slot_live && (status == STATUS_OK))
    else $error("granted slot not live");

endmodule

bind entity_slot_allocator esa_checker u_esa_checker (.*);
